/* design/blf_pkg.sv */
package blf_pkg;

  // Fixed widths of the item fields and configuration registers.
  localparam int unsigned LevelW   = 7;
  localparam int unsigned AlphaW   = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // Level limits and filter constants.
  localparam logic [LevelW-1:0] LevelMax      = 7'd100;
  localparam logic [LevelW-1:0] EdgeLow       = 7'd5;
  localparam logic [LevelW-1:0] EdgeHigh      = 7'd95;
  localparam logic [LevelW-1:0] LedSolidLevel = 7'd97;
  localparam logic [CountW-1:0] CountMax      = 4'd15;
  localparam logic [23:0]       RoundHalf     = 24'd32768;

  // Register reset values.
  localparam logic [AlphaW-1:0] AlphaReset     = 16'd6553;
  localparam logic [15:0]       SeedDelayReset = 16'd15000;
  localparam logic [CountW-1:0] SeedSampReset  = 4'd3;
  localparam logic [CountW-1:0] ConfirmReset   = 4'd3;
  localparam logic [LevelW-1:0] StepReset      = 7'd1;
  localparam logic [LevelW-1:0] LowThrReset    = 7'd20;
  localparam logic [LevelW-1:0] CritThrReset   = 7'd10;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMA_ALPHA     = 3'd0,
    CFG_SEED_DELAY    = 3'd1,
    CFG_SEED_SAMPLES  = 3'd2,
    CFG_CONFIRM_COUNT = 3'd3,
    CFG_CONVERGE_STEP = 3'd4,
    CFG_LOW_THR       = 3'd5,
    CFG_CRIT_THR      = 3'd6
  } cfg_idx_e;

  // Result codes.
  typedef enum logic [1:0] {
    THR_NONE = 2'd0,
    THR_LOW  = 2'd1,
    THR_CRIT = 2'd2
  } thr_evt_e;

  typedef enum logic [1:0] {
    CHG_EVT_NONE  = 2'd0,
    CHG_EVT_START = 2'd1,
    CHG_EVT_STOP  = 2'd2
  } chg_evt_e;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_BREATH = 2'd1,
    LED_SOLID = 2'd2
  } led_e;

  // Current register settings, handed from the register file to the datapath.
  typedef struct packed {
    logic [AlphaW-1:0] ema_alpha;
    logic [15:0]       seed_delay_ms;
    logic [CountW-1:0] seed_samples;
    logic [CountW-1:0] confirm_count;
    logic [LevelW-1:0] converge_step;
    logic [LevelW-1:0] low_threshold;
    logic [LevelW-1:0] critical_threshold;
  } cfg_t;

  // One input transaction as held in the input register.
  typedef struct packed {
    logic signed [15:0] soc_reading;
    logic               soc_valid;
    logic               charging;
    logic [31:0]        uptime_ms;
  } in_item_t;

  // One result transaction as held in the result register.
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              chg_state;
    logic              level_changed;
    logic [1:0]        threshold_event;
    logic [1:0]        charge_event;
    logic [1:0]        led_mode;
  } out_item_t;

endpackage

/* design/blf_if.sv */
// Input channel: one gauge sample per transaction.
interface blf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] soc_reading;
  logic               soc_valid;
  logic               charging;
  logic [31:0]        uptime_ms;

  modport source (output valid, output soc_reading, output soc_valid, output charging,
                  output uptime_ms, input ready);
  modport sink (input valid, input soc_reading, input soc_valid, input charging,
                input uptime_ms, output ready);
endinterface

// Output channel: one filtered result per transaction.
interface blf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] level;
  logic       chg_state;
  logic       level_changed;
  logic [1:0] threshold_event;
  logic [1:0] charge_event;
  logic [1:0] led_mode;

  modport source (output valid, output level, output chg_state, output level_changed,
                  output threshold_event, output charge_event, output led_mode,
                  input ready);
  modport sink (input valid, input level, input chg_state, input level_changed,
                input threshold_event, input charge_event, input led_mode,
                output ready);
endinterface

/* design/blf_cfg_regs.sv */
module blf_cfg_regs
  import blf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ema_alpha          <= AlphaReset;
      cfg_q.seed_delay_ms      <= SeedDelayReset;
      cfg_q.seed_samples       <= SeedSampReset;
      cfg_q.confirm_count      <= ConfirmReset;
      cfg_q.converge_step      <= StepReset;
      cfg_q.low_threshold      <= LowThrReset;
      cfg_q.critical_threshold <= CritThrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EMA_ALPHA:     cfg_q.ema_alpha          <= cfg_data_i;
        CFG_SEED_DELAY:    cfg_q.seed_delay_ms      <= cfg_data_i;
        CFG_SEED_SAMPLES:  cfg_q.seed_samples       <= cfg_data_i[CountW-1:0];
        CFG_CONFIRM_COUNT: cfg_q.confirm_count      <= cfg_data_i[CountW-1:0];
        CFG_CONVERGE_STEP: cfg_q.converge_step      <= cfg_data_i[LevelW-1:0];
        CFG_LOW_THR:       cfg_q.low_threshold      <= cfg_data_i[LevelW-1:0];
        CFG_CRIT_THR:      cfg_q.critical_threshold <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/blf_ema.sv */
module blf_ema
  import blf_pkg::*;
(
  input  logic [AlphaW-1:0] alpha_i,
  input  logic [LevelW-1:0] cur_i,
  input  logic [LevelW-1:0] sample_i,
  input  logic              charging_i,
  output logic [LevelW-1:0] next_o
);

  logic [AlphaW-1:0] alpha_inv;
  logic [22:0] prod_new;
  logic [22:0] prod_old;
  logic [23:0] acc;

  // Weight of the old value: 65535 minus alpha, kept at the register width.
  assign alpha_inv = ~alpha_i;

  // Weighted sum of new sample and old value, rounded to the nearest step.
  assign prod_new = 23'(alpha_i) * 23'(sample_i);
  assign prod_old = 23'(alpha_inv) * 23'(cur_i);
  assign acc      = 24'(prod_new) + 24'(prod_old) + RoundHalf;

  // Near the ends the value moves one point per sample in the charge direction.
  always_comb begin
    if (!charging_i && (cur_i <= EdgeLow) && (sample_i < cur_i)) begin
      next_o = cur_i - 7'd1;
    end else if (charging_i && (cur_i >= EdgeHigh) && (sample_i > cur_i)) begin
      next_o = cur_i + 7'd1;
    end else begin
      next_o = acc[22:16];
    end
  end

endmodule

/* design/battery_level_filter_unit.sv */
// An accepted input transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while the output accepts results; the input
// register, the filter logic and the result register form a two-stage pipeline with
// the filter state updated as each item leaves the input register.
// Reset: asynchronous, active low; clears the filter state, the valid flags and
// loads the register reset values.
module battery_level_filter_unit
  import blf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  blf_in_if.sink              in_i,
  blf_out_if.source           out_o
);

  cfg_t        cfg;
  in_item_t    in_q;
  logic        in_v_q;
  out_item_t   out_q;
  out_item_t   out_d;
  logic        out_v_q;
  logic        advance;

  logic [LevelW-1:0] level_q;
  logic              chg_q;
  logic [LevelW-1:0] ema_q;
  logic [LevelW-1:0] ema_d;
  logic              ema_rdy_q;
  logic              ema_rdy_d;
  logic [CountW-1:0] seed_cnt_q;
  logic [CountW-1:0] seed_cnt_d;
  logic [CountW-1:0] conv_cnt_q;
  logic [CountW-1:0] conv_cnt_d;

  logic [LevelW-1:0] raw;
  logic              seed_hold;
  logic [CountW-1:0] seed_inc;
  logic [CountW-1:0] conv_inc;
  logic [LevelW-1:0] ema_nxt;
  logic              with_dir;
  logic [LevelW-1:0] diff_up;
  logic [LevelW-1:0] diff_dn;
  logic [LevelW-1:0] res;
  logic [LevelW-1:0] new_level;

  blf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: an item moves on when the result register is free or being drained.
  assign advance     = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready  = !in_v_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.soc_reading <= in_i.soc_reading;
      in_q.soc_valid   <= in_i.soc_valid;
      in_q.charging    <= in_i.charging;
      in_q.uptime_ms   <= in_i.uptime_ms;
    end
  end

  // Clamp the reading to 0..100.
  always_comb begin
    if (in_q.soc_reading[15]) begin
      raw = '0;
    end else if (in_q.soc_reading[14:0] > 15'(LevelMax)) begin
      raw = LevelMax;
    end else begin
      raw = in_q.soc_reading[LevelW-1:0];
    end
  end

  assign seed_hold = in_q.uptime_ms < 32'(cfg.seed_delay_ms);
  assign seed_inc  = (seed_cnt_q == CountMax) ? CountMax : seed_cnt_q + 4'd1;
  assign conv_inc  = (conv_cnt_q == CountMax) ? CountMax : conv_cnt_q + 4'd1;

  blf_ema u_ema (
    .alpha_i    (cfg.ema_alpha),
    .cur_i      (ema_q),
    .sample_i   (raw),
    .charging_i (in_q.charging),
    .next_o     (ema_nxt)
  );

  assign with_dir = in_q.charging ? (ema_nxt >= ema_q) : (ema_nxt <= ema_q);
  assign diff_up  = ema_nxt - ema_q;
  assign diff_dn  = ema_q - ema_nxt;

  // Filter: raw value during seeding, then EMA with counter-direction limiting.
  always_comb begin
    ema_d      = ema_q;
    ema_rdy_d  = ema_rdy_q;
    seed_cnt_d = seed_cnt_q;
    conv_cnt_d = conv_cnt_q;
    res        = ema_q;
    new_level  = level_q;
    if (in_q.soc_valid) begin
      if (!ema_rdy_q) begin
        new_level = raw;
        if (!seed_hold) begin
          ema_d      = raw;
          seed_cnt_d = seed_inc;
          if (seed_inc >= cfg.seed_samples) begin
            ema_rdy_d = 1'b1;
          end
        end
      end else begin
        if (with_dir) begin
          res        = ema_nxt;
          conv_cnt_d = '0;
        end else begin
          conv_cnt_d = conv_inc;
          if (conv_inc >= cfg.confirm_count) begin
            if (ema_nxt > ema_q) begin
              res = ema_q + ((cfg.converge_step < diff_up) ? cfg.converge_step : diff_up);
            end else begin
              res = ema_q - ((cfg.converge_step < diff_dn) ? cfg.converge_step : diff_dn);
            end
          end
        end
        if (res > LevelMax) begin
          res = LevelMax;
        end
        ema_d     = res;
        new_level = res;
      end
    end
  end

  // Result fields: events and LED mode.
  always_comb begin
    out_d.level           = new_level;
    out_d.chg_state       = in_q.charging;
    out_d.level_changed   = new_level != level_q;
    out_d.threshold_event = THR_NONE;
    out_d.charge_event    = CHG_EVT_NONE;
    if (out_d.level_changed) begin
      if (new_level <= cfg.critical_threshold) begin
        out_d.threshold_event = THR_CRIT;
      end else if (new_level <= cfg.low_threshold) begin
        out_d.threshold_event = THR_LOW;
      end
    end
    if (in_q.charging != chg_q) begin
      out_d.charge_event = in_q.charging ? CHG_EVT_START : CHG_EVT_STOP;
    end
    if (!in_q.charging) begin
      out_d.led_mode = LED_OFF;
    end else if (new_level >= LedSolidLevel) begin
      out_d.led_mode = LED_SOLID;
    end else begin
      out_d.led_mode = LED_BREATH;
    end
  end

  // Filter state, updated as each item passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      chg_q      <= 1'b0;
      ema_q      <= '0;
      ema_rdy_q  <= 1'b0;
      seed_cnt_q <= '0;
      conv_cnt_q <= '0;
    end else if (advance) begin
      level_q    <= new_level;
      chg_q      <= in_q.charging;
      ema_q      <= ema_d;
      ema_rdy_q  <= ema_rdy_d;
      seed_cnt_q <= seed_cnt_d;
      conv_cnt_q <= conv_cnt_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.level           = out_q.level;
  assign out_o.chg_state       = out_q.chg_state;
  assign out_o.level_changed   = out_q.level_changed;
  assign out_o.threshold_event = out_q.threshold_event;
  assign out_o.charge_event    = out_q.charge_event;
  assign out_o.led_mode        = out_q.led_mode;

  // A threshold event only accompanies a level change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.threshold_event != THR_NONE)) |-> out_q.level_changed)
    else $error("threshold event without level change");

  // Solid LED only while charging at a high level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.led_mode == LED_SOLID)) |->
      (out_q.chg_state && (out_q.level >= LedSolidLevel)))
    else $error("solid LED without charging at high level");

  // The reported level and the filter value stay within 0..100.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q <= LevelMax) && (ema_q <= LevelMax))
    else $error("level out of range");

  // Once seeded the filter stays seeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ema_rdy_q |=> ema_rdy_q)
    else $error("filter lost its seeded state");

endmodule
